// ===== src/rha_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB/HSV adjust package
// Shared constants and codes for the RGB to HSV analysis and recomposition.
// ----------------------------------------------------------------------------
package rha_pkg;

  // Hue is held in 1/64 degree; one 60-degree sector is 3840 units.
  localparam logic [14:0] HUE_SECTOR  = 15'd3840;
  localparam logic [14:0] HUE_FULL    = 15'd23040;
  localparam logic [11:0] HALF_SECTOR = 12'd1920;

  // Sector starts used for the hue offset base.
  localparam logic [15:0] BASE_GREEN  = 16'd7680;
  localparam logic [15:0] BASE_BLUE   = 16'd15360;

  // Q0.16 full scale and half of it for rounding.
  localparam logic [15:0] SAT_ONE     = 16'd65535;
  localparam logic [15:0] SAT_HALF    = 16'd32767;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    PRIM_RED,
    PRIM_GREEN,
    PRIM_BLUE
  } prim_t;

endpackage

// ===== src/rgb_hsv_adjust_top.sv =====
// ----------------------------------------------------------------------------
// RGB/HSV adjust top level
// Pipelined RGB to HSV analysis with optional hue/saturation recomposition.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one RGB colour, a
//   replacement hue and saturation and two replace flags per request.
//   Output channel (out_valid / out_stall) returns hue, saturation, value
//   and the recomposed RGB colour for each request, in order.
//   The pipeline has 26 stages. Throughput is one request per cycle while
//   the receiver does not stall the output; the saturation division produces
//   one quotient bit per stage over 16 stages, and the hue division does the
//   same over the first 12.
//   When the receiver stalls with a result on the port, the whole pipeline
//   holds and in_stall is raised in the same cycle; nothing is lost or
//   repeated. While the output register is empty the pipeline keeps moving.
//   Synchronous active-low reset clears all valid bits; payload registers
//   are not reset. The block has no state beyond the pipeline.
// ----------------------------------------------------------------------------
module rgb_hsv_adjust_top #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CHANNEL_BITS-1:0] in_red_in,
  input  logic [CHANNEL_BITS-1:0] in_green_in,
  input  logic [CHANNEL_BITS-1:0] in_blue_in,
  input  logic [14:0]             in_new_hue,
  input  logic [15:0]             in_new_saturation,
  input  logic                    in_replace_hue,
  input  logic                    in_replace_saturation,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [14:0]             out_hue_out,
  output logic [15:0]             out_saturation_out,
  output logic [15:0]             out_value_out,
  output logic [15:0]             out_red_out,
  output logic [15:0]             out_green_out,
  output logic [15:0]             out_blue_out
);
  import rha_pkg::*;

  localparam int CB   = CHANNEL_BITS;
  localparam int HRW  = CB + 12;
  localparam int SRW  = CB + 16;
  localparam int PW   = CB + 16;
  localparam int ZW   = CB + 4;
  localparam int RS   = ((ZW + 3) / 4) * 4;
  localparam logic [RS-1:0] RECIP15 = RS'({RS{1'b1}} / 15);
  localparam int NDIV = 16;

  // Values carried along the whole pipeline.
  typedef struct packed {
    logic [15:0]   r;
    logic [15:0]   g;
    logic [15:0]   b;
    logic [CB-1:0] mx;
    logic [14:0]   hrep;
    logic [15:0]   ns;
    logic          rep_h;
    logic          rep_s;
  } ctx_t;

  // Hue control carried through the divider.
  typedef struct packed {
    prim_t sel;
    logic  neg;
    logic  dz;
    logic  mz;
  } hctl_t;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Stage A: maximum, minimum and the dominant channel.
  // --------------------------------------------------------------------------
  logic [CB-1:0] mx_c, mn_c, opa_c, opb_c;
  prim_t         sel_c;
  logic [14:0]   hrep_c;
  ctx_t          ctx_c;

  always_comb begin
    mx_c = in_red_in;
    if (in_green_in > mx_c) mx_c = in_green_in;
    if (in_blue_in > mx_c) mx_c = in_blue_in;
    mn_c = in_red_in;
    if (in_green_in < mn_c) mn_c = in_green_in;
    if (in_blue_in < mn_c) mn_c = in_blue_in;
    if (mx_c == in_red_in) begin
      sel_c = PRIM_RED;
      opa_c = in_green_in;
      opb_c = in_blue_in;
    end else if (mx_c == in_green_in) begin
      sel_c = PRIM_GREEN;
      opa_c = in_blue_in;
      opb_c = in_red_in;
    end else begin
      sel_c = PRIM_BLUE;
      opa_c = in_red_in;
      opb_c = in_green_in;
    end
    hrep_c = (in_new_hue >= HUE_FULL) ? in_new_hue - HUE_FULL : in_new_hue;
    ctx_c.r     = 16'(in_red_in);
    ctx_c.g     = 16'(in_green_in);
    ctx_c.b     = 16'(in_blue_in);
    ctx_c.mx    = mx_c;
    ctx_c.hrep  = hrep_c;
    ctx_c.ns    = in_new_saturation;
    ctx_c.rep_h = in_replace_hue;
    ctx_c.rep_s = in_replace_saturation;
  end

  logic          va_r;
  ctx_t          a_ctx_r;
  logic [CB-1:0] a_opa_r, a_opb_r, a_d_r;
  prim_t         a_sel_r;

  // --------------------------------------------------------------------------
  // Stage B: hue offset magnitude and the two division numerators.
  // --------------------------------------------------------------------------
  logic [CB-1:0]  num_c;
  logic           neg_c;
  logic [HRW-1:0] hnum_c;
  logic [SRW-1:0] snum_c;
  hctl_t          hctl_c;

  always_comb begin
    neg_c  = a_opa_r < a_opb_r;
    num_c  = neg_c ? a_opb_r - a_opa_r : a_opa_r - a_opb_r;
    hnum_c = {num_c, 12'd0} - {4'd0, num_c, 8'd0} + HRW'(a_d_r >> 1);
    snum_c = {a_d_r, 16'd0} - SRW'(a_d_r) + SRW'(a_ctx_r.mx >> 1);
    hctl_c.sel = a_sel_r;
    hctl_c.neg = neg_c;
    hctl_c.dz  = (a_d_r == '0);
    hctl_c.mz  = (a_ctx_r.mx == '0);
  end

  // --------------------------------------------------------------------------
  // Divider stages: one quotient bit per stage for both divisions.
  // Index 0 holds stage B; index k+1 holds the result of divider step k.
  // --------------------------------------------------------------------------
  logic           dv_r   [0:NDIV];
  ctx_t           dctx_r [0:NDIV];
  hctl_t          dhc_r  [0:NDIV];
  logic [CB-1:0]  dd_r   [0:NDIV];
  logic [HRW-1:0] hrem_r [0:NDIV];
  logic [11:0]    hq_r   [0:NDIV];
  logic [SRW-1:0] srem_r [0:NDIV];
  logic [15:0]    sq_r   [0:NDIV];

  logic [HRW-1:0] hrem_nxt [1:NDIV];
  logic [11:0]    hq_nxt   [1:NDIV];
  logic [SRW-1:0] srem_nxt [1:NDIV];
  logic [15:0]    sq_nxt   [1:NDIV];

  always_comb begin
    logic [HRW-1:0] htrial;
    logic [SRW-1:0] strial;
    for (int k = 0; k < NDIV; k++) begin
      // Hue quotient has 12 bits; later steps only carry it.
      htrial = HRW'(dd_r[k]) << (11 - (k % 12));
      if (k < 12 && hrem_r[k] >= htrial) begin
        hrem_nxt[k+1] = hrem_r[k] - htrial;
        hq_nxt[k+1]   = {hq_r[k][10:0], 1'b1};
      end else if (k < 12) begin
        hrem_nxt[k+1] = hrem_r[k];
        hq_nxt[k+1]   = {hq_r[k][10:0], 1'b0};
      end else begin
        hrem_nxt[k+1] = hrem_r[k];
        hq_nxt[k+1]   = hq_r[k];
      end
      // Saturation quotient has 16 bits.
      strial = SRW'(dctx_r[k].mx) << (15 - k);
      if (srem_r[k] >= strial) begin
        srem_nxt[k+1] = srem_r[k] - strial;
        sq_nxt[k+1]   = {sq_r[k][14:0], 1'b1};
      end else begin
        srem_nxt[k+1] = srem_r[k];
        sq_nxt[k+1]   = {sq_r[k][14:0], 1'b0};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: finish hue and saturation, choose the recomposition inputs.
  // --------------------------------------------------------------------------
  logic [15:0] hbase_c, hsum_c;
  logic [14:0] hue_c, hsel_c;
  logic [15:0] sat_c, ssel_c;

  always_comb begin
    case (dhc_r[NDIV].sel)
      PRIM_RED:   hbase_c = '0;
      PRIM_GREEN: hbase_c = BASE_GREEN;
      default:    hbase_c = BASE_BLUE;
    endcase
    if (dhc_r[NDIV].neg) begin
      hsum_c = hbase_c + 16'(HUE_FULL) - 16'(hq_r[NDIV]);
    end else begin
      hsum_c = hbase_c + 16'(hq_r[NDIV]);
    end
    if (hsum_c >= 16'(HUE_FULL)) hsum_c = hsum_c - 16'(HUE_FULL);
    hue_c  = dhc_r[NDIV].dz ? '0 : hsum_c[14:0];
    sat_c  = dhc_r[NDIV].mz ? '0 : sq_r[NDIV];
    hsel_c = dctx_r[NDIV].rep_h ? dctx_r[NDIV].hrep : hue_c;
    ssel_c = dctx_r[NDIV].rep_s ? dctx_r[NDIV].ns : sat_c;
  end

  logic        ve_r;
  ctx_t        e_ctx_r;
  logic [14:0] e_hue_r, e_h_r;
  logic [15:0] e_sat_r, e_s_r;

  // --------------------------------------------------------------------------
  // Stage F: v*s product, hue sector and offset within it.
  // --------------------------------------------------------------------------
  logic [2:0]  sec_c;
  logic [14:0] secb_c;

  always_comb begin
    if (e_h_r < 15'd3840) begin
      sec_c = 3'd0; secb_c = 15'd0;
    end else if (e_h_r < 15'd7680) begin
      sec_c = 3'd1; secb_c = 15'd3840;
    end else if (e_h_r < 15'd11520) begin
      sec_c = 3'd2; secb_c = 15'd7680;
    end else if (e_h_r < 15'd15360) begin
      sec_c = 3'd3; secb_c = 15'd11520;
    end else if (e_h_r < 15'd19200) begin
      sec_c = 3'd4; secb_c = 15'd15360;
    end else begin
      sec_c = 3'd5; secb_c = 15'd19200;
    end
  end

  logic          vf_r;
  ctx_t          f_ctx_r;
  logic [14:0]   f_hue_r;
  logic [15:0]   f_sat_r;
  logic [PW-1:0] f_p_r;
  logic [2:0]    f_sec_r;
  logic [11:0]   f_f_r;

  // --------------------------------------------------------------------------
  // Stage G: estimate c = round(v*s / 65535) by a shifted series.
  // --------------------------------------------------------------------------
  logic [PW-1:0] y_c, qe_c, rem_c;

  always_comb begin
    y_c   = f_p_r + PW'(SAT_HALF);
    qe_c  = (y_c >> 16) + (y_c >> 32);
    rem_c = y_c - (qe_c << 16) + qe_c;
  end

  logic          vg_r;
  ctx_t          g_ctx_r;
  logic [14:0]   g_hue_r;
  logic [15:0]   g_sat_r;
  logic [CB-1:0] g_qe_r;
  logic [17:0]   g_rem_r;
  logic [2:0]    g_sec_r;
  logic [11:0]   g_f_r;

  // --------------------------------------------------------------------------
  // Stage H: correct the estimate of c and pick the ramp factor.
  // --------------------------------------------------------------------------
  logic [CB-1:0] c_c;
  logic [11:0]   k_c;

  always_comb begin
    c_c = g_qe_r + CB'(g_rem_r >= 18'(SAT_ONE))
                 + CB'(g_rem_r >= 18'({SAT_ONE, 1'b0}));
    k_c = g_sec_r[0] ? 12'(HUE_SECTOR) - g_f_r : g_f_r;
  end

  logic          vh_r;
  ctx_t          h_ctx_r;
  logic [14:0]   h_hue_r;
  logic [15:0]   h_sat_r;
  logic [CB-1:0] h_c_r;
  logic [11:0]   h_k_r;
  logic [2:0]    h_sec_r;

  // --------------------------------------------------------------------------
  // Stage I: c*k plus half a sector, pre-divided by 256; m = v - c.
  // --------------------------------------------------------------------------
  logic [HRW-1:0] ck_c;

  always_comb begin
    ck_c = HRW'(h_c_r) * HRW'(h_k_r) + HRW'(HALF_SECTOR);
  end

  logic          vi_r;
  ctx_t          i_ctx_r;
  logic [14:0]   i_hue_r;
  logic [15:0]   i_sat_r;
  logic [CB-1:0] i_c_r, i_m_r;
  logic [ZW-1:0] i_z_r;
  logic [2:0]    i_sec_r;

  // --------------------------------------------------------------------------
  // Stage J: multiply by the reciprocal of 15.
  // --------------------------------------------------------------------------
  logic             vj_r;
  ctx_t             j_ctx_r;
  logic [14:0]      j_hue_r;
  logic [15:0]      j_sat_r;
  logic [CB-1:0]    j_c_r, j_m_r;
  logic [ZW-1:0]    j_z_r;
  logic [ZW+RS-1:0] j_zm_r;
  logic [2:0]       j_sec_r;

  // --------------------------------------------------------------------------
  // Stage K: correct the quotient to give x.
  // --------------------------------------------------------------------------
  logic [ZW-1:0] qx_c, xr_c;
  logic [CB-1:0] x_c;

  always_comb begin
    qx_c = j_zm_r[ZW+RS-1:RS];
    xr_c = j_z_r - ((qx_c << 4) - qx_c);
    x_c  = CB'(qx_c) + CB'(xr_c >= ZW'(15));
  end

  logic          vk_r;
  ctx_t          k_ctx_r;
  logic [14:0]   k_hue_r;
  logic [15:0]   k_sat_r;
  logic [CB-1:0] k_c_r, k_m_r, k_x_r;
  logic [2:0]    k_sec_r;

  // --------------------------------------------------------------------------
  // Stage L: place c and x by sector, add m, or pass the input through.
  // --------------------------------------------------------------------------
  logic [CB-1:0] cr_c, cg_c, cb_c;
  logic [15:0]   ro_c, go_c, bo_c;

  always_comb begin
    case (k_sec_r)
      3'd0:    begin cr_c = k_c_r; cg_c = k_x_r; cb_c = '0;    end
      3'd1:    begin cr_c = k_x_r; cg_c = k_c_r; cb_c = '0;    end
      3'd2:    begin cr_c = '0;    cg_c = k_c_r; cb_c = k_x_r; end
      3'd3:    begin cr_c = '0;    cg_c = k_x_r; cb_c = k_c_r; end
      3'd4:    begin cr_c = k_x_r; cg_c = '0;    cb_c = k_c_r; end
      default: begin cr_c = k_c_r; cg_c = '0;    cb_c = k_x_r; end
    endcase
    if (k_ctx_r.rep_h || k_ctx_r.rep_s) begin
      ro_c = 16'(cr_c + k_m_r);
      go_c = 16'(cg_c + k_m_r);
      bo_c = 16'(cb_c + k_m_r);
    end else begin
      ro_c = k_ctx_r.r;
      go_c = k_ctx_r.g;
      bo_c = k_ctx_r.b;
    end
  end

  logic        out_valid_r;
  logic [14:0] out_hue_r;
  logic [15:0] out_sat_r, out_val_r, out_red_r, out_green_r, out_blue_r;

  // Valid bits: cleared by reset, advance with the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      vh_r        <= 1'b0;
      vi_r        <= 1'b0;
      vj_r        <= 1'b0;
      vk_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NDIV; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      va_r     <= in_valid;
      dv_r[0]  <= va_r;
      for (int k = 1; k <= NDIV; k++) dv_r[k] <= dv_r[k-1];
      ve_r        <= dv_r[NDIV];
      vf_r        <= ve_r;
      vg_r        <= vf_r;
      vh_r        <= vg_r;
      vi_r        <= vh_r;
      vj_r        <= vi_r;
      vk_r        <= vj_r;
      out_valid_r <= vk_r;
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx_r <= ctx_c;
      a_opa_r <= opa_c;
      a_opb_r <= opb_c;
      a_d_r   <= mx_c - mn_c;
      a_sel_r <= sel_c;

      dctx_r[0] <= a_ctx_r;
      dhc_r[0]  <= hctl_c;
      dd_r[0]   <= a_d_r;
      hrem_r[0] <= hnum_c;
      hq_r[0]   <= '0;
      srem_r[0] <= snum_c;
      sq_r[0]   <= '0;
      for (int k = 1; k <= NDIV; k++) begin
        dctx_r[k] <= dctx_r[k-1];
        dhc_r[k]  <= dhc_r[k-1];
        dd_r[k]   <= dd_r[k-1];
        hrem_r[k] <= hrem_nxt[k];
        hq_r[k]   <= hq_nxt[k];
        srem_r[k] <= srem_nxt[k];
        sq_r[k]   <= sq_nxt[k];
      end

      e_ctx_r <= dctx_r[NDIV];
      e_hue_r <= hue_c;
      e_sat_r <= sat_c;
      e_h_r   <= hsel_c;
      e_s_r   <= ssel_c;

      f_ctx_r <= e_ctx_r;
      f_hue_r <= e_hue_r;
      f_sat_r <= e_sat_r;
      f_p_r   <= PW'(e_ctx_r.mx) * PW'(e_s_r);
      f_sec_r <= sec_c;
      f_f_r   <= 12'(e_h_r - secb_c);

      g_ctx_r <= f_ctx_r;
      g_hue_r <= f_hue_r;
      g_sat_r <= f_sat_r;
      g_qe_r  <= CB'(qe_c);
      g_rem_r <= rem_c[17:0];
      g_sec_r <= f_sec_r;
      g_f_r   <= f_f_r;

      h_ctx_r <= g_ctx_r;
      h_hue_r <= g_hue_r;
      h_sat_r <= g_sat_r;
      h_c_r   <= c_c;
      h_k_r   <= k_c;
      h_sec_r <= g_sec_r;

      i_ctx_r <= h_ctx_r;
      i_hue_r <= h_hue_r;
      i_sat_r <= h_sat_r;
      i_c_r   <= h_c_r;
      i_m_r   <= h_ctx_r.mx - h_c_r;
      i_z_r   <= ck_c[HRW-1:8];
      i_sec_r <= h_sec_r;

      j_ctx_r <= i_ctx_r;
      j_hue_r <= i_hue_r;
      j_sat_r <= i_sat_r;
      j_c_r   <= i_c_r;
      j_m_r   <= i_m_r;
      j_z_r   <= i_z_r;
      j_zm_r  <= (ZW+RS)'(i_z_r) * (ZW+RS)'(RECIP15);
      j_sec_r <= i_sec_r;

      k_ctx_r <= j_ctx_r;
      k_hue_r <= j_hue_r;
      k_sat_r <= j_sat_r;
      k_c_r   <= j_c_r;
      k_m_r   <= j_m_r;
      k_x_r   <= x_c;
      k_sec_r <= j_sec_r;

      out_hue_r   <= k_hue_r;
      out_sat_r   <= k_sat_r;
      out_val_r   <= 16'(k_ctx_r.mx);
      out_red_r   <= ro_c;
      out_green_r <= go_c;
      out_blue_r  <= bo_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hue_out        = out_hue_r;
  assign out_saturation_out = out_sat_r;
  assign out_value_out      = out_val_r;
  assign out_red_out        = out_red_r;
  assign out_green_out      = out_green_r;
  assign out_blue_out       = out_blue_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The input is held off exactly when a result waits on a stalled port.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output stall");

  // A reported hue always lies below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_out < HUE_FULL))
    else $error("hue out of range");

  // The chroma from the scaled v*s product never exceeds the value.
  a_chroma_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vi_r |-> (i_c_r <= i_ctx_r.mx))
    else $error("chroma exceeds value");

  // The ramp term never exceeds the chroma.
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vk_r |-> (k_x_r <= k_c_r))
    else $error("ramp term exceeds chroma");

endmodule
